[rtl/pva_pkg.sv]
// Package for the polyphonic voice allocator.
// Holds codes, the controller/datapath command and status structs.
// No dependencies.
package pva_pkg;

  localparam logic [1:0] MODE_NOTE_ON  = 2'd0;
  localparam logic [1:0] MODE_NOTE_OFF = 2'd1;
  localparam logic [1:0] MODE_ALL_OFF  = 2'd2;
  localparam logic [1:0] MODE_FINISHED = 2'd3;

  localparam logic [2:0] ST_ASSIGNED = 3'd0;
  localparam logic [2:0] ST_STOLEN   = 3'd1;
  localparam logic [2:0] ST_RELEASED = 3'd2;
  localparam logic [2:0] ST_IGNORED  = 3'd3;
  localparam logic [2:0] ST_CLEARED  = 3'd4;
  localparam logic [2:0] ST_FREED    = 3'd5;

  localparam logic [3:0] DRUM_CHANNEL = 4'd9;
  localparam int         NUM_KEYS     = 128;

  localparam logic REG_VOICE_LIMIT  = 1'b0;
  localparam logic REG_RELEASE_MODE = 1'b1;

  typedef enum logic [2:0] {
    POS_HOLD, POS_ZERO, POS_LAST, POS_INC, POS_DEC, POS_BEST
  } pos_op_e;

  typedef enum logic [1:0] {
    T_ORD, T_S, T_BEST, T_VID
  } tsel_e;

  typedef enum logic [1:0] {
    PC_CH, PC_BEST, PC_SLOT
  } pcsel_e;

  typedef enum logic [1:0] {
    W_RD, W_BEST, W_POS
  } ord_wsel_e;

  typedef struct packed {
    logic       load;
    pos_op_e    pos_op;
    logic       ord_rd_next;
    logic       ord_we;
    ord_wsel_e  ord_wsel;
    tsel_e      tsel;
    logic       s_ld;
    logic       sd_we;
    logic       alive_set;
    logic       alive_clr;
    logic       rel_set;
    logic       clear_all;
    logic       total_inc;
    logic       total_dec;
    pcsel_e     pcsel;
    logic       pc_inc;
    logic       pc_dec;
    logic       best_try;
    logic       cnt_inc;
    logic       res_init;
    logic       res_set;
    logic [2:0] res_status;
    logic       slot_ld;
    logic       out_load;
    logic       clr_done;
  } cmd_t;

  typedef struct packed {
    logic       clr_pend;
    logic [1:0] mode;
    logic       ignore;
    logic       note_off;
    logic       ord_alive;
    logic       ord_rel;
    logic       vid_ok;
    logic       pos_zero;
    logic       pos_last;
    logic       pos_max;
    logic       match;
    logic       first_only;
    logic       out_busy;
  } stat_t;

endpackage

[rtl/pva_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pva_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/pva_datapath.sv]
// Datapath of the voice allocator: order list and slot RAMs, voice flags,
// counters, scan position and the result register. Uses pva_pkg, pva_ram.
module pva_datapath #(
  parameter int MAX_VOICES = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pva_pkg::cmd_t cmd_i,
  output pva_pkg::stat_t stat_o,
  input  logic [25:0]   item_i,
  input  logic [6:0]    limit_i,
  input  logic          first_only_i,
  input  logic          limit_wr_i,
  input  logic          m_tready_i,
  output logic          m_tvalid_o,
  output logic [31:0]   m_tdata_o
);

  localparam int SW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int CW = $clog2(MAX_VOICES + 1);

  logic [1:0] mode_q;
  logic [3:0] ch_q;
  logic [6:0] note_q, vel_q;
  logic [5:0] vid_q;

  logic [SW-1:0] pos_q, pos_d, lim_m1, ord_raddr, ord_wdata, ord_rdata, target;
  logic [SW-1:0] s_q, best_s_q, best_idx_q, vid_idx;
  logic [6:0]    best_vel_q;
  logic [3:0]    best_ch_q;
  logic [17:0]   sd_rdata;
  logic [3:0]    sd_ch, pc_idx;
  logic [6:0]    sd_note, sd_vel;

  logic [MAX_VOICES-1:0] alive_q, alive_d, rel_q, rel_d;
  logic [CW-1:0] per_ch_q [16];
  logic [CW-1:0] per_ch_d [16];
  logic [CW-1:0] pc_cur, total_q, total_d;
  logic [CW-1:0] cnt_q;
  logic [2:0]    status_q;
  logic [5:0]    vslot_q;
  logic          clr_pend_q, out_valid_q;

  assign sd_ch   = sd_rdata[17:14];
  assign sd_note = sd_rdata[13:7];
  assign sd_vel  = sd_rdata[6:0];
  assign vid_idx = SW'(vid_q);

  always_comb begin
    if (limit_i == 7'd0) begin
      lim_m1 = '0;
    end else if (int'(limit_i) > MAX_VOICES) begin
      lim_m1 = SW'(MAX_VOICES - 1);
    end else begin
      lim_m1 = SW'(limit_i - 7'd1);
    end
  end

  always_comb begin
    case (cmd_i.pos_op)
      pva_pkg::POS_ZERO: pos_d = '0;
      pva_pkg::POS_LAST: pos_d = lim_m1;
      pva_pkg::POS_INC:  pos_d = pos_q + SW'(1);
      pva_pkg::POS_DEC:  pos_d = pos_q - SW'(1);
      pva_pkg::POS_BEST: pos_d = best_idx_q;
      default:           pos_d = pos_q;
    endcase
  end

  assign ord_raddr = cmd_i.ord_rd_next ? pos_q + SW'(1) : pos_q;

  always_comb begin
    case (cmd_i.ord_wsel)
      pva_pkg::W_BEST: ord_wdata = best_s_q;
      pva_pkg::W_POS:  ord_wdata = pos_q;
      default:         ord_wdata = ord_rdata;
    endcase
  end

  always_comb begin
    case (cmd_i.tsel)
      pva_pkg::T_S:    target = s_q;
      pva_pkg::T_BEST: target = best_s_q;
      pva_pkg::T_VID:  target = vid_idx;
      default:         target = ord_rdata;
    endcase
  end

  pva_ram #(.WIDTH(SW), .DEPTH(MAX_VOICES)) u_order_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.ord_we),
    .waddr_i (pos_q),
    .wdata_i (ord_wdata),
    .raddr_i (ord_raddr),
    .rdata_o (ord_rdata)
  );

  pva_ram #(.WIDTH(18), .DEPTH(MAX_VOICES)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.sd_we),
    .waddr_i (target),
    .wdata_i ({ch_q, note_q, vel_q}),
    .raddr_i (target),
    .rdata_o (sd_rdata)
  );

  always_comb begin
    alive_d = alive_q;
    rel_d   = rel_q;
    for (int i = 0; i < MAX_VOICES; i++) begin
      if (cmd_i.clear_all || limit_wr_i) begin
        alive_d[i] = 1'b0;
        rel_d[i]   = 1'b0;
      end else if (target == SW'(i)) begin
        if (cmd_i.alive_set) begin
          alive_d[i] = 1'b1;
          rel_d[i]   = 1'b0;
        end else if (cmd_i.alive_clr) begin
          alive_d[i] = 1'b0;
          rel_d[i]   = 1'b0;
        end else if (cmd_i.rel_set) begin
          rel_d[i] = 1'b1;
        end
      end
    end
  end

  always_comb begin
    case (cmd_i.pcsel)
      pva_pkg::PC_BEST: pc_idx = best_ch_q;
      pva_pkg::PC_SLOT: pc_idx = sd_ch;
      default:          pc_idx = ch_q;
    endcase
  end
  assign pc_cur = per_ch_q[pc_idx];

  always_comb begin
    per_ch_d = per_ch_q;
    total_d  = total_q;
    if (cmd_i.clear_all || limit_wr_i) begin
      for (int i = 0; i < 16; i++) begin
        per_ch_d[i] = '0;
      end
      total_d = '0;
    end else begin
      if (cmd_i.pc_inc) begin
        per_ch_d[pc_idx] = pc_cur + CW'(1);
      end else if (cmd_i.pc_dec && pc_cur != '0) begin
        per_ch_d[pc_idx] = pc_cur - CW'(1);
      end
      if (cmd_i.total_inc) begin
        total_d = total_q + CW'(1);
      end else if (cmd_i.total_dec && total_q != '0) begin
        total_d = total_q - CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      alive_q     <= '0;
      rel_q       <= '0;
      total_q     <= '0;
      clr_pend_q  <= 1'b1;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 16; i++) begin
        per_ch_q[i] <= '0;
      end
    end else begin
      pos_q    <= pos_d;
      alive_q  <= alive_d;
      rel_q    <= rel_d;
      total_q  <= total_d;
      per_ch_q <= per_ch_d;
      if (limit_wr_i) begin
        clr_pend_q <= 1'b1;
      end else if (cmd_i.clr_done) begin
        clr_pend_q <= 1'b0;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= item_i[1:0];
      ch_q   <= item_i[5:2];
      note_q <= item_i[12:6];
      vel_q  <= item_i[19:13];
      vid_q  <= item_i[25:20];
    end
    if (cmd_i.s_ld) begin
      s_q <= ord_rdata;
    end
    if (cmd_i.best_try && (pos_q == '0 || sd_vel < best_vel_q)) begin
      best_idx_q <= pos_q;
      best_s_q   <= s_q;
      best_vel_q <= sd_vel;
      best_ch_q  <= sd_ch;
    end
    if (cmd_i.res_init) begin
      cnt_q   <= '0;
      vslot_q <= '0;
    end else begin
      if (cmd_i.cnt_inc) begin
        cnt_q <= cnt_q + CW'(1);
      end
      if (cmd_i.slot_ld) begin
        vslot_q <= 6'(target);
      end
    end
    if (cmd_i.res_set) begin
      status_q <= cmd_i.res_status;
    end
    if (cmd_i.out_load) begin
      m_tdata_o <= {2'b00, 7'(pc_cur), 7'(total_q), 7'(cnt_q), vslot_q, status_q};
    end
  end

  assign m_tvalid_o = out_valid_q;

  always_comb begin
    stat_o.clr_pend   = clr_pend_q;
    stat_o.mode       = mode_q;
    stat_o.ignore     = (ch_q == pva_pkg::DRUM_CHANNEL) ||
                        ({1'b0, note_q} >= 8'(pva_pkg::NUM_KEYS));
    stat_o.note_off   = (mode_q == pva_pkg::MODE_NOTE_OFF) || (vel_q == 7'd0);
    stat_o.ord_alive  = alive_q[ord_rdata];
    stat_o.ord_rel    = rel_q[ord_rdata];
    stat_o.vid_ok     = ({3'b000, vid_q} < 9'(MAX_VOICES)) && alive_q[vid_idx];
    stat_o.pos_zero   = (pos_q == '0);
    stat_o.pos_last   = (pos_q == lim_m1);
    stat_o.pos_max    = (pos_q == SW'(MAX_VOICES - 1));
    stat_o.match      = (sd_ch == ch_q) && (sd_note == note_q);
    stat_o.first_only = first_only_i;
    stat_o.out_busy   = out_valid_q && !m_tready_i;
  end

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(total_q) <= MAX_VOICES)
    else $error("active voice count beyond slot count");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> !(out_valid_q && !m_tready_i))
    else $error("result overwritten before it was taken");

  a_clear_zeroes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear_all |=> (total_q == '0 && alive_q == '0))
    else $error("clear left voices sounding");

  a_limit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    limit_wr_i |=> (clr_pend_q && alive_q == '0))
    else $error("limit write did not start the order rebuild");

endmodule

[rtl/pva_ctrl.sv]
// Controller state machine of the voice allocator: sequences scans over the
// order list and issues commands to the datapath. Uses pva_pkg.
module pva_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  pva_pkg::stat_t stat_i,
  output pva_pkg::cmd_t  cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_CLR, S_DEC, S_ON_RD, S_ON_WT, S_ST_RD, S_ST_WO, S_ST_WS, S_ST_END,
    S_SH_CHK, S_SH_WT, S_SH_LAST, S_ST_INC, S_OFF_RD, S_OFF_WO, S_OFF_WS,
    S_OFF_NXT, S_FIN, S_RES
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE) && !stat_i.clr_pend;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (stat_i.clr_pend) begin
          cmd_o.pos_op = pva_pkg::POS_ZERO;
          state_d      = S_CLR;
        end else if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DEC;
        end
      end
      S_CLR: begin
        cmd_o.ord_we   = 1'b1;
        cmd_o.ord_wsel = pva_pkg::W_POS;
        if (stat_i.pos_max) begin
          cmd_o.clr_done = 1'b1;
          state_d        = S_IDLE;
        end else begin
          cmd_o.pos_op = pva_pkg::POS_INC;
        end
      end
      S_DEC: begin
        cmd_o.res_init = 1'b1;
        unique case (stat_i.mode)
          pva_pkg::MODE_NOTE_ON, pva_pkg::MODE_NOTE_OFF: begin
            if (stat_i.ignore) begin
              cmd_o.res_set    = 1'b1;
              cmd_o.res_status = pva_pkg::ST_IGNORED;
              state_d          = S_RES;
            end else if (stat_i.note_off) begin
              cmd_o.pos_op = pva_pkg::POS_LAST;
              state_d      = S_OFF_RD;
            end else begin
              cmd_o.pos_op = pva_pkg::POS_ZERO;
              state_d      = S_ON_RD;
            end
          end
          pva_pkg::MODE_ALL_OFF: begin
            cmd_o.clear_all  = 1'b1;
            cmd_o.res_set    = 1'b1;
            cmd_o.res_status = pva_pkg::ST_CLEARED;
            state_d          = S_RES;
          end
          default: begin
            cmd_o.tsel = pva_pkg::T_VID;
            if (stat_i.vid_ok) begin
              state_d = S_FIN;
            end else begin
              cmd_o.res_set    = 1'b1;
              cmd_o.res_status = pva_pkg::ST_IGNORED;
              state_d          = S_RES;
            end
          end
        endcase
      end
      S_ON_RD: state_d = S_ON_WT;
      S_ON_WT: begin
        if (!stat_i.ord_alive) begin
          cmd_o.tsel       = pva_pkg::T_ORD;
          cmd_o.sd_we      = 1'b1;
          cmd_o.alive_set  = 1'b1;
          cmd_o.total_inc  = 1'b1;
          cmd_o.pcsel      = pva_pkg::PC_CH;
          cmd_o.pc_inc     = 1'b1;
          cmd_o.slot_ld    = 1'b1;
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = pva_pkg::ST_ASSIGNED;
          state_d          = S_RES;
        end else if (stat_i.pos_last) begin
          cmd_o.pos_op = pva_pkg::POS_ZERO;
          state_d      = S_ST_RD;
        end else begin
          cmd_o.pos_op = pva_pkg::POS_INC;
          state_d      = S_ON_RD;
        end
      end
      S_ST_RD: state_d = S_ST_WO;
      S_ST_WO: begin
        cmd_o.s_ld = 1'b1;
        cmd_o.tsel = pva_pkg::T_ORD;
        state_d    = S_ST_WS;
      end
      S_ST_WS: begin
        cmd_o.best_try = 1'b1;
        if (stat_i.pos_last) begin
          state_d = S_ST_END;
        end else begin
          cmd_o.pos_op = pva_pkg::POS_INC;
          state_d      = S_ST_RD;
        end
      end
      S_ST_END: begin
        cmd_o.pos_op = pva_pkg::POS_BEST;
        state_d      = S_SH_CHK;
      end
      S_SH_CHK: begin
        if (stat_i.pos_last) begin
          state_d = S_SH_LAST;
        end else begin
          cmd_o.ord_rd_next = 1'b1;
          state_d           = S_SH_WT;
        end
      end
      S_SH_WT: begin
        // data read at pos+1 moves down one place
        cmd_o.ord_we   = 1'b1;
        cmd_o.ord_wsel = pva_pkg::W_RD;
        cmd_o.pos_op   = pva_pkg::POS_INC;
        state_d        = S_SH_CHK;
      end
      S_SH_LAST: begin
        cmd_o.ord_we    = 1'b1;
        cmd_o.ord_wsel  = pva_pkg::W_BEST;
        cmd_o.tsel      = pva_pkg::T_BEST;
        cmd_o.sd_we     = 1'b1;
        cmd_o.alive_set = 1'b1;
        cmd_o.pcsel     = pva_pkg::PC_BEST;
        cmd_o.pc_dec    = 1'b1;
        cmd_o.slot_ld   = 1'b1;
        state_d         = S_ST_INC;
      end
      S_ST_INC: begin
        cmd_o.pcsel      = pva_pkg::PC_CH;
        cmd_o.pc_inc     = 1'b1;
        cmd_o.res_set    = 1'b1;
        cmd_o.res_status = pva_pkg::ST_STOLEN;
        state_d          = S_RES;
      end
      S_OFF_RD: state_d = S_OFF_WO;
      S_OFF_WO: begin
        cmd_o.s_ld = 1'b1;
        cmd_o.tsel = pva_pkg::T_ORD;
        state_d    = (stat_i.ord_alive && !stat_i.ord_rel) ? S_OFF_WS : S_OFF_NXT;
      end
      S_OFF_WS: begin
        state_d = S_OFF_NXT;
        if (stat_i.match) begin
          cmd_o.tsel    = pva_pkg::T_S;
          cmd_o.rel_set = 1'b1;
          cmd_o.cnt_inc = 1'b1;
          if (stat_i.first_only) begin
            cmd_o.res_set    = 1'b1;
            cmd_o.res_status = pva_pkg::ST_RELEASED;
            state_d          = S_RES;
          end
        end
      end
      S_OFF_NXT: begin
        if (stat_i.pos_zero) begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = pva_pkg::ST_RELEASED;
          state_d          = S_RES;
        end else begin
          cmd_o.pos_op = pva_pkg::POS_DEC;
          state_d      = S_OFF_RD;
        end
      end
      S_FIN: begin
        cmd_o.tsel       = pva_pkg::T_VID;
        cmd_o.alive_clr  = 1'b1;
        cmd_o.total_dec  = 1'b1;
        cmd_o.pcsel      = pva_pkg::PC_SLOT;
        cmd_o.pc_dec     = 1'b1;
        cmd_o.res_set    = 1'b1;
        cmd_o.res_status = pva_pkg::ST_FREED;
        state_d          = S_RES;
      end
      S_RES: begin
        cmd_o.pcsel = pva_pkg::PC_CH;
        if (!stat_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_load_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> (state_q == S_IDLE && !stat_i.clr_pend))
    else $error("request taken outside idle");

  a_flag_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.alive_set && cmd_o.alive_clr))
    else $error("voice both started and freed");

  a_clr_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.clr_done |=> state_q == S_IDLE)
    else $error("order rebuild did not return to idle");

endmodule

[rtl/polyphonic_voice_allocator.sv]
// Polyphonic voice allocator, top level: stream ports, APB register port.
// Depends on pva_pkg, pva_ctrl, pva_datapath (and pva_ram beneath it).
//
// One request is handled at a time; the order list and slot data sit in
// RAMs and are scanned one position per step.
// A note-on takes the first free slot in the order list; if there is none,
// it steals the voice of lowest velocity by a free search, a velocity scan
// and an order shift. A note-off scans the order list from the last position
// down. A result still waiting at the output holds up the next result.
// After reset and after every write to voice_limit the order list is rebuilt,
// one entry a cycle, during which tready is low.
// A finished result waits in an output register.
module polyphonic_voice_allocator #(
  parameter int MAX_VOICES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // mode[1:0], channel[5:2], note[12:6], velocity[19:13], voice_id[25:20]
  input  logic [31:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // status[2:0], voice_slot[8:3], released_count[15:9], active_voices[22:16],
  // channel_voices[29:23]
  output logic [31:0] m_axis_tdata_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  pva_pkg::cmd_t  cmd;
  pva_pkg::stat_t stat;
  logic [6:0] limit_q;
  logic       first_only_q;
  logic       cfg_wr, limit_wr;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign limit_wr = cfg_wr && (paddr[2] == pva_pkg::REG_VOICE_LIMIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q      <= 7'd64;
      first_only_q <= 1'b1;
    end else if (cfg_wr) begin
      if (paddr[2] == pva_pkg::REG_VOICE_LIMIT) begin
        limit_q <= pwdata[6:0];
      end else begin
        first_only_q <= pwdata[0];
      end
    end
  end

  assign prdata = (paddr[2] == pva_pkg::REG_RELEASE_MODE) ? {31'd0, first_only_q}
                                                          : {25'd0, limit_q};

  pva_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pva_datapath #(.MAX_VOICES(MAX_VOICES)) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .item_i       (s_axis_tdata_i[25:0]),
    .limit_i      (limit_q),
    .first_only_i (first_only_q),
    .limit_wr_i   (limit_wr),
    .m_tready_i   (m_axis_tready_i),
    .m_tvalid_o   (m_axis_tvalid_o),
    .m_tdata_o    (m_axis_tdata_o)
  );

endmodule
